// ===== hdl/caps_pkg.sv =====
// ----------------------------------------------------------------------------
// caps_pkg
// Shared types and constants of the circle arc pixel stepper: field widths,
// transaction structs, sequencer states and square root unit status.
// ----------------------------------------------------------------------------
`default_nettype none

package caps_pkg;

	// field widths
	localparam int COORD_BITS            = 20;
	localparam int RADIUS_BITS           = 18;
	localparam int PIXEL_BITS            = 16;
	localparam int FRACTION_BITS_DEFAULT = 4;

	// derived widths
	localparam int OFFSET_BITS = COORD_BITS + 1;
	localparam int SQ_BITS     = 2 * RADIUS_BITS;
	localparam int ROOT_STEPS  = RADIUS_BITS;

	// operation codes
	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_STEP = 1'b1;

	// quadrant codes of the end point
	localparam logic [1:0] QUAD_1 = 2'd0;
	localparam logic [1:0] QUAD_2 = 2'd1;
	localparam logic [1:0] QUAD_3 = 2'd2;
	localparam logic [1:0] QUAD_4 = 2'd3;

	// input transaction
	typedef struct packed {
		logic                          operation;
		logic signed [COORD_BITS-1:0]  ctr_x;
		logic signed [COORD_BITS-1:0]  ctr_y;
		logic signed [COORD_BITS-1:0]  start_x;
		logic signed [COORD_BITS-1:0]  start_y;
		logic signed [COORD_BITS-1:0]  end_x;
		logic signed [COORD_BITS-1:0]  end_y;
		logic        [RADIUS_BITS-1:0] radius;
	} caps_in_t;

	// result transaction
	typedef struct packed {
		logic signed [PIXEL_BITS-1:0] pixel_x;
		logic signed [PIXEL_BITS-1:0] pixel_y;
		logic                         point_valid;
		logic                         arc_done;
	} caps_out_t;

	// sequencer states
	typedef enum logic [2:0] {
		S_IDLE,
		S_LOAD_SQ,
		S_MOVE,
		S_MULT,
		S_PREP,
		S_ROOT,
		S_FINISH
	} caps_state_t;

	// square root unit status
	typedef struct packed {
		logic busy;
		logic done;
	} caps_root_stat_t;

endpackage

`default_nettype wire

// ===== hdl/caps_root.sv =====
// ----------------------------------------------------------------------------
// caps_root
// Bit-serial integer square root: floor(sqrt(radicand)), one result bit per
// cycle, with a one-cycle done pulse at the end.
// ----------------------------------------------------------------------------
`default_nettype none

module caps_root (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               start,
	input  wire logic [caps_pkg::SQ_BITS-1:0]       radicand,
	output caps_pkg::caps_root_stat_t               stat,
	output logic      [caps_pkg::RADIUS_BITS-1:0]   root
);

	localparam int SQ_W  = caps_pkg::SQ_BITS;
	localparam int CNT_W = $clog2(caps_pkg::ROOT_STEPS);
	localparam logic [SQ_W-1:0]  BIT_INIT  = {2'b01, {(SQ_W-2){1'b0}}};
	localparam logic [CNT_W-1:0] CNT_LAST  = CNT_W'(caps_pkg::ROOT_STEPS - 1);

	logic [SQ_W-1:0]  rem_q;
	logic [SQ_W-1:0]  res_q;
	logic [SQ_W-1:0]  bit_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [SQ_W:0]    trial;
	logic             take;

	// trial subtraction of one iteration
	assign trial = {1'b0, res_q} + {1'b0, bit_q};
	assign take  = {1'b0, rem_q} >= trial;

	// iteration control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_LAST;
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// remainder, partial root and bit weight
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= radicand;
			res_q <= '0;
			bit_q <= BIT_INIT;
		end else if (busy_q) begin
			if (take) begin
				rem_q <= rem_q - trial[SQ_W-1:0];
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign root      = res_q[caps_pkg::RADIUS_BITS-1:0];

	// a new root is never started on top of a running one
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q)
		else $error("root started while busy");

	// done only follows a busy cycle
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy_q))
		else $error("root done without iteration");

	// the bit weight does not run out before the last iteration
	a_bit_live: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (bit_q != '0))
		else $error("root bit weight empty while busy");

endmodule

`default_nettype wire

// ===== hdl/circle_arc_pixel_stepper_top.sv =====
// ----------------------------------------------------------------------------
// circle_arc_pixel_stepper_top
// Steps a circular arc one pixel per step transaction, from a loaded start
// point toward a loaded end point, in signed fixed point coordinates.
// ----------------------------------------------------------------------------
// A load transaction is accepted, then the radius is squared, and it gives no
// result. A step transaction on an active arc runs through the states in
// order: move and clamp the minor coordinate, square it on the shared
// multiplier, form the radicand and start the bit-serial square root unit
// (one root bit per cycle), wait for its done pulse, then finish and register
// the result; the next transaction is accepted only once the sequencer is
// back in idle. A step with no active arc goes straight to finish and gives
// its done result, then frees the input. The input is not ready while a
// transaction is in work, and a finished result stalls the sequencer only if
// the previous result has not been taken yet.
`default_nettype none

module circle_arc_pixel_stepper_top #(
	parameter int FRACTION_BITS = caps_pkg::FRACTION_BITS_DEFAULT
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire caps_pkg::caps_in_t in_item,
	output logic               out_valid,
	input  wire logic          out_ready,
	output caps_pkg::caps_out_t out_item
);

	localparam int CW     = caps_pkg::COORD_BITS;
	localparam int OW     = caps_pkg::OFFSET_BITS;
	localparam int RW     = caps_pkg::RADIUS_BITS;
	localparam int SW     = caps_pkg::SQ_BITS;
	localparam int PW     = caps_pkg::PIXEL_BITS;
	localparam int STEP_W = OW + 1;
	localparam int WIDE_W = STEP_W + PW;

	localparam logic signed [STEP_W-1:0] ONE_W   = STEP_W'(1 << FRACTION_BITS);
	localparam logic signed [WIDE_W-1:0] BIAS_W  = WIDE_W'((1 << FRACTION_BITS) - 1);
	localparam logic        [RW-1:0]     MIN_RAD = RW'((3 * (1 << FRACTION_BITS)) / 2);
	localparam caps_pkg::caps_out_t DONE_ITEM = '{
		pixel_x: '0, pixel_y: '0, point_valid: 1'b0, arc_done: 1'b1};

	caps_pkg::caps_state_t state_q, state_d;

	// arc state
	logic signed [CW-1:0] centre_x_q, centre_y_q;
	logic signed [OW-1:0] offset_x_q, offset_y_q;
	logic signed [OW-1:0] end_off_x_q, end_off_y_q;
	logic        [RW-1:0] radius_q;
	logic        [SW-1:0] r2_q;
	logic        [1:0]    end_quad_q;
	logic                 arc_active_q;

	// step working registers
	logic signed [RW:0]   minor_q;
	logic                 minor_is_x_q;
	logic                 major_neg_q;
	logic        [SW-1:0] prod_q;
	logic                 skip_q;

	// result register
	caps_pkg::caps_out_t  out_item_q;
	logic                 out_valid_q;

	logic                 in_fire, out_free, root_start;
	caps_pkg::caps_root_stat_t root_stat;
	logic        [RW-1:0] root_val;

	// ------------------------------------------------------------------
	// sequencer
	// ------------------------------------------------------------------
	assign in_fire  = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= caps_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		in_ready   = 1'b0;
		root_start = 1'b0;
		unique case (state_q)
			caps_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (in_item.operation == caps_pkg::OP_LOAD) begin
						state_d = caps_pkg::S_LOAD_SQ;
					end else if (arc_active_q) begin
						state_d = caps_pkg::S_MOVE;
					end else begin
						state_d = caps_pkg::S_FINISH;
					end
				end
			end
			caps_pkg::S_LOAD_SQ: state_d = caps_pkg::S_IDLE;
			caps_pkg::S_MOVE:    state_d = caps_pkg::S_MULT;
			caps_pkg::S_MULT:    state_d = caps_pkg::S_PREP;
			caps_pkg::S_PREP: begin
				root_start = 1'b1;
				state_d    = caps_pkg::S_ROOT;
			end
			caps_pkg::S_ROOT: begin
				if (root_stat.done) begin
					state_d = caps_pkg::S_FINISH;
				end
			end
			caps_pkg::S_FINISH: begin
				if (out_free) begin
					state_d = caps_pkg::S_IDLE;
				end
			end
			default: state_d = caps_pkg::S_IDLE;
		endcase
	end

	// ------------------------------------------------------------------
	// load: offsets from center and end quadrant
	// ------------------------------------------------------------------
	logic signed [OW-1:0] ld_off_x, ld_off_y, ld_end_x, ld_end_y;
	logic        [1:0]    ld_quad;

	assign ld_off_x = {in_item.start_x[CW-1], in_item.start_x}
		- {in_item.ctr_x[CW-1], in_item.ctr_x};
	assign ld_off_y = {in_item.start_y[CW-1], in_item.start_y}
		- {in_item.ctr_y[CW-1], in_item.ctr_y};
	assign ld_end_x = {in_item.end_x[CW-1], in_item.end_x}
		- {in_item.ctr_x[CW-1], in_item.ctr_x};
	assign ld_end_y = {in_item.end_y[CW-1], in_item.end_y}
		- {in_item.ctr_y[CW-1], in_item.ctr_y};

	always_comb begin
		if (ld_end_x >= 0 && ld_end_y > 0) begin
			ld_quad = caps_pkg::QUAD_1;
		end else if (ld_end_x < 0 && ld_end_y >= 0) begin
			ld_quad = caps_pkg::QUAD_2;
		end else if (ld_end_x <= 0 && ld_end_y < 0) begin
			ld_quad = caps_pkg::QUAD_3;
		end else begin
			ld_quad = caps_pkg::QUAD_4;
		end
	end

	// ------------------------------------------------------------------
	// move: direction from quadrant, advance minor coordinate, clamp
	// ------------------------------------------------------------------
	logic signed [STEP_W-1:0] ox_w, oy_w, mag_x, mag_y;
	logic signed [STEP_W-1:0] moved, hi_lim, lo_lim, clamped;
	logic                     x_dec, y_dec, x_neg, y_neg, mv_minor_x;

	assign ox_w  = {offset_x_q[OW-1], offset_x_q};
	assign oy_w  = {offset_y_q[OW-1], offset_y_q};
	assign mag_x = (ox_w < 0) ? -ox_w : ox_w;
	assign mag_y = (oy_w < 0) ? -oy_w : oy_w;

	always_comb begin
		if (ox_w > 0 && oy_w >= 0) begin
			x_dec = 1'b1; y_dec = 1'b0; x_neg = 1'b0; y_neg = 1'b0;
		end else if (ox_w <= 0 && oy_w > 0) begin
			x_dec = 1'b1; y_dec = 1'b1; x_neg = 1'b1; y_neg = 1'b0;
		end else if (ox_w < 0 && oy_w <= 0) begin
			x_dec = 1'b0; y_dec = 1'b1; x_neg = 1'b1; y_neg = 1'b1;
		end else begin
			x_dec = 1'b0; y_dec = 1'b0; x_neg = 1'b0; y_neg = 1'b1;
		end
	end

	assign mv_minor_x = mag_x < mag_y;
	assign hi_lim     = $signed({{(STEP_W-RW){1'b0}}, radius_q});
	assign lo_lim     = -hi_lim;

	always_comb begin
		if (mv_minor_x) begin
			moved = x_dec ? (ox_w - ONE_W) : (ox_w + ONE_W);
		end else begin
			moved = y_dec ? (oy_w - ONE_W) : (oy_w + ONE_W);
		end
		if (moved < lo_lim) begin
			clamped = lo_lim;
		end else if (moved > hi_lim) begin
			clamped = hi_lim;
		end else begin
			clamped = moved;
		end
	end

	// ------------------------------------------------------------------
	// shared multiplier: radius squared at load, minor squared at step
	// ------------------------------------------------------------------
	logic signed [RW:0]   minor_abs;
	logic        [RW-1:0] minor_mag, mul_a;
	logic        [SW-1:0] product;

	assign minor_abs = (minor_q < 0) ? -minor_q : minor_q;
	assign minor_mag = minor_abs[RW-1:0];
	assign mul_a     = (state_q == caps_pkg::S_LOAD_SQ) ? radius_q : minor_mag;
	assign product   = SW'(mul_a) * SW'(mul_a);

	// radicand r^2 - c^2, zero when the minor coordinate reaches the radius
	logic [SW-1:0] radicand;
	assign radicand = (r2_q > prod_q) ? (r2_q - prod_q) : '0;

	caps_root u_root (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (root_start),
		.radicand (radicand),
		.stat     (root_stat),
		.root     (root_val)
	);

	// ------------------------------------------------------------------
	// finish: new offsets, end test, truncated pixel
	// ------------------------------------------------------------------
	logic signed [OW-1:0]     root_ext, major, minor_ext, new_x, new_y;
	logic                     end_met;
	logic signed [STEP_W-1:0] sum_x, sum_y;
	logic signed [WIDE_W-1:0] wide_x, wide_y, trunc_x, trunc_y;

	assign root_ext  = $signed({{(OW-RW){1'b0}}, root_val});
	assign major     = major_neg_q ? -root_ext : root_ext;
	assign minor_ext = {{(OW-RW-1){minor_q[RW]}}, minor_q};
	assign new_x     = minor_is_x_q ? minor_ext : major;
	assign new_y     = minor_is_x_q ? major : minor_ext;

	always_comb begin
		unique case (end_quad_q)
			caps_pkg::QUAD_1: end_met = (new_x <= end_off_x_q) && (new_y >= 0);
			caps_pkg::QUAD_2: end_met = (new_y <= end_off_y_q) && (new_x <= 0);
			caps_pkg::QUAD_3: end_met = (new_x >= end_off_x_q) && (new_y <= 0);
			default:          end_met = (new_y >= end_off_y_q) && (new_x >= 0);
		endcase
	end

	// division by one pixel, rounded toward zero
	assign sum_x   = {{(STEP_W-CW){centre_x_q[CW-1]}}, centre_x_q} + {new_x[OW-1], new_x};
	assign sum_y   = {{(STEP_W-CW){centre_y_q[CW-1]}}, centre_y_q} + {new_y[OW-1], new_y};
	assign wide_x  = {{PW{sum_x[STEP_W-1]}}, sum_x};
	assign wide_y  = {{PW{sum_y[STEP_W-1]}}, sum_y};
	assign trunc_x = ((wide_x < 0) ? (wide_x + BIAS_W) : wide_x) >>> FRACTION_BITS;
	assign trunc_y = ((wide_y < 0) ? (wide_y + BIAS_W) : wide_y) >>> FRACTION_BITS;

	// ------------------------------------------------------------------
	// datapath registers
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		case (state_q)
			caps_pkg::S_IDLE: begin
				if (in_fire && in_item.operation == caps_pkg::OP_LOAD) begin
					centre_x_q  <= in_item.ctr_x;
					centre_y_q  <= in_item.ctr_y;
					offset_x_q  <= ld_off_x;
					offset_y_q  <= ld_off_y;
					end_off_x_q <= ld_end_x;
					end_off_y_q <= ld_end_y;
					radius_q    <= in_item.radius;
					end_quad_q  <= ld_quad;
				end
				if (in_fire) begin
					skip_q <= !arc_active_q;
				end
			end
			caps_pkg::S_LOAD_SQ: r2_q <= product;
			caps_pkg::S_MOVE: begin
				minor_q      <= clamped[RW:0];
				minor_is_x_q <= mv_minor_x;
				major_neg_q  <= mv_minor_x ? y_neg : x_neg;
			end
			caps_pkg::S_MULT: prod_q <= product;
			caps_pkg::S_FINISH: begin
				if (out_free) begin
					if (skip_q || end_met) begin
						out_item_q <= DONE_ITEM;
					end else begin
						out_item_q.pixel_x     <= trunc_x[PW-1:0];
						out_item_q.pixel_y     <= trunc_y[PW-1:0];
						out_item_q.point_valid <= 1'b1;
						out_item_q.arc_done    <= 1'b0;
					end
					if (!skip_q) begin
						offset_x_q <= new_x;
						offset_y_q <= new_y;
					end
				end
			end
			default: ;
		endcase
	end

	// arc activity
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			arc_active_q <= 1'b0;
		end else if (in_fire && in_item.operation == caps_pkg::OP_LOAD) begin
			arc_active_q <= in_item.radius > MIN_RAD;
		end else if (state_q == caps_pkg::S_FINISH && out_free && !skip_q && end_met) begin
			arc_active_q <= 1'b0;
		end
	end

	// result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == caps_pkg::S_FINISH && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

	// ------------------------------------------------------------------
	// assertions
	// ------------------------------------------------------------------
	a_root_to_finish: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == caps_pkg::S_ROOT) && root_stat.done |=> state_q == caps_pkg::S_FINISH)
		else $error("root result not taken by finish");

	a_move_active: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == caps_pkg::S_MOVE) |-> arc_active_q)
		else $error("step moved on an inactive arc");

	a_minor_clamped: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == caps_pkg::S_MULT) |-> (minor_mag <= radius_q))
		else $error("minor coordinate beyond radius");

	a_result_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_item_q.point_valid != out_item_q.arc_done))
		else $error("result is both or neither pixel and done");

endmodule

`default_nettype wire

// ===== sim/circle_arc_pixel_stepper_top_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circle_arc_pixel_stepper_top_test
// Drives load and step transactions into the arc stepper and checks every
// result against a cycle-free model of the arc walk kept in the bench. A short
// directed set covers the field extremes, the small radius cutoff, steps with
// no arc, starts off the circle and pixel wrap. Random arcs follow, mostly
// well formed with start and end on the circle, the rest random noise. Both
// handshakes idle at random in repeating phases.
// ----------------------------------------------------------------------------

module circle_arc_pixel_stepper_top_test;

	localparam longint ONE = longint'(1) << caps_pkg::FRACTION_BITS_DEFAULT;
	localparam longint MIN_RADIUS = (3 * ONE) / 2;
	localparam int RANDOM_ITEMS = 550;
	localparam int PHASE_ITEMS = 60;
	localparam int DRAIN_CYCLES = 30;

	typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	caps_pkg::caps_in_t in_item = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	caps_pkg::caps_out_t out_item;

	// pending stimulus and predicted results
	caps_pkg::caps_in_t arc_items[$];
	caps_pkg::caps_out_t expected_pixels[$];
	logic in_taken = 1'b0;
	int issued = 0;
	int mismatches = 0;

	// arc state as the block holds it after reset
	logic signed [caps_pkg::COORD_BITS-1:0] arc_cx = '0;
	logic signed [caps_pkg::COORD_BITS-1:0] arc_cy = '0;
	logic signed [caps_pkg::OFFSET_BITS-1:0] arc_off_x = '0;
	logic signed [caps_pkg::OFFSET_BITS-1:0] arc_off_y = '0;
	logic signed [caps_pkg::OFFSET_BITS-1:0] arc_end_x = '0;
	logic signed [caps_pkg::OFFSET_BITS-1:0] arc_end_y = '0;
	logic [caps_pkg::RADIUS_BITS-1:0] arc_radius = '0;
	logic [caps_pkg::SQ_BITS-1:0] arc_radius_sq = '0;
	logic [1:0] arc_end_quad = caps_pkg::QUAD_1;
	logic arc_live = 1'b0;

	circle_arc_pixel_stepper_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_item(in_item),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_item(out_item)
	);

	always #5 clk = ~clk;

	// floor of the square root, one root bit at a time
	function automatic longint floor_root(input longint n);
		longint root;
		longint trial;
		root = 0;
		for (int b = 19; b >= 0; b--) begin
			trial = root | (longint'(1) << b);
			if (trial * trial <= n)
				root = trial;
		end
		return root;
	endfunction

	// signed major coordinate on the circle for a given minor one
	function automatic longint major_from_minor(input longint c, input longint sgn);
		longint sq;
		longint rsq;
		sq = c * c;
		rsq = longint'(arc_radius_sq);
		if (rsq > sq)
			return sgn * floor_root(rsq - sq);
		return 0;
	endfunction

	// apply one accepted transaction to the arc state, queue its result
	task automatic trace_arc_item(input caps_pkg::caps_in_t item);
		longint x, y, r, dx, dy, sx, sy, ex, ey, cx, cy, p;
		logic done;
		caps_pkg::caps_out_t res;
		if (item.operation == caps_pkg::OP_LOAD) begin
			cx = longint'($signed(item.ctr_x));
			cy = longint'($signed(item.ctr_y));
			x = longint'($signed(item.start_x)) - cx;
			y = longint'($signed(item.start_y)) - cy;
			ex = longint'($signed(item.end_x)) - cx;
			ey = longint'($signed(item.end_y)) - cy;
			r = longint'(item.radius);
			arc_cx = item.ctr_x;
			arc_cy = item.ctr_y;
			arc_off_x = x[caps_pkg::OFFSET_BITS-1:0];
			arc_off_y = y[caps_pkg::OFFSET_BITS-1:0];
			arc_end_x = ex[caps_pkg::OFFSET_BITS-1:0];
			arc_end_y = ey[caps_pkg::OFFSET_BITS-1:0];
			arc_radius = item.radius;
			p = r * r;
			arc_radius_sq = p[caps_pkg::SQ_BITS-1:0];
			if (ex >= 0 && ey > 0)
				arc_end_quad = caps_pkg::QUAD_1;
			else if (ex < 0 && ey >= 0)
				arc_end_quad = caps_pkg::QUAD_2;
			else if (ex <= 0 && ey < 0)
				arc_end_quad = caps_pkg::QUAD_3;
			else
				arc_end_quad = caps_pkg::QUAD_4;
			arc_live = r > MIN_RADIUS;
		end else begin
			res = '0;
			res.arc_done = 1'b1;
			if (arc_live) begin
				x = longint'(arc_off_x);
				y = longint'(arc_off_y);
				r = longint'(arc_radius);
				// counterclockwise direction from the current quadrant
				if (x > 0 && y >= 0) begin
					dx = -ONE; dy = ONE; sx = 1; sy = 1;
				end else if (x <= 0 && y > 0) begin
					dx = -ONE; dy = -ONE; sx = -1; sy = 1;
				end else if (x < 0 && y <= 0) begin
					dx = ONE; dy = -ONE; sx = -1; sy = -1;
				end else begin
					dx = ONE; dy = ONE; sx = 1; sy = -1;
				end
				// minor coordinate moves one pixel, major follows the circle
				if ((x < 0 ? -x : x) < (y < 0 ? -y : y)) begin
					x = x + dx;
					if (x < -r)
						x = -r;
					else if (x > r)
						x = r;
					y = major_from_minor(x, sy);
				end else begin
					y = y + dy;
					if (y < -r)
						y = -r;
					else if (y > r)
						y = r;
					x = major_from_minor(y, sx);
				end
				arc_off_x = x[caps_pkg::OFFSET_BITS-1:0];
				arc_off_y = y[caps_pkg::OFFSET_BITS-1:0];
				ex = longint'(arc_end_x);
				ey = longint'(arc_end_y);
				// end test per end quadrant
				case (arc_end_quad)
					caps_pkg::QUAD_1: done = (x <= ex) && (y >= 0);
					caps_pkg::QUAD_2: done = (y <= ey) && (x <= 0);
					caps_pkg::QUAD_3: done = (x >= ex) && (y <= 0);
					default: done = (y >= ey) && (x >= 0);
				endcase
				if (done) begin
					arc_live = 1'b0;
				end else begin
					p = (longint'(arc_cx) + x) / ONE;
					res.pixel_x = p[caps_pkg::PIXEL_BITS-1:0];
					p = (longint'(arc_cy) + y) / ONE;
					res.pixel_y = p[caps_pkg::PIXEL_BITS-1:0];
					res.point_valid = 1'b1;
					res.arc_done = 1'b0;
				end
			end
			expected_pixels.push_back(res);
		end
	endtask

	// transaction with every field random
	function automatic caps_pkg::caps_in_t random_item(input logic op);
		logic [159:0] bits;
		caps_pkg::caps_in_t item;
		bits = {$urandom, $urandom, $urandom, $urandom, $urandom};
		item = bits[$bits(caps_pkg::caps_in_t)-1:0];
		item.operation = op;
		return item;
	endfunction

	// one load followed by a run of steps
	task automatic queue_arc(input longint cx, cy, px, py, ex, ey, r, input int steps);
		caps_pkg::caps_in_t item;
		item = random_item(caps_pkg::OP_LOAD);
		item.ctr_x = cx[caps_pkg::COORD_BITS-1:0];
		item.ctr_y = cy[caps_pkg::COORD_BITS-1:0];
		item.start_x = px[caps_pkg::COORD_BITS-1:0];
		item.start_y = py[caps_pkg::COORD_BITS-1:0];
		item.end_x = ex[caps_pkg::COORD_BITS-1:0];
		item.end_y = ey[caps_pkg::COORD_BITS-1:0];
		item.radius = r[caps_pkg::RADIUS_BITS-1:0];
		arc_items.push_back(item);
		repeat (steps)
			arc_items.push_back(random_item(caps_pkg::OP_STEP));
	endtask

	// random point on the circle
	task automatic circle_point(input longint r, cx, cy, output longint px, py);
		longint d, h;
		d = longint'($urandom_range(2 * r)) - r;
		h = floor_root(r * r - d * d);
		if ($urandom_range(1))
			h = -h;
		if ($urandom_range(1)) begin
			px = cx + d; py = cy + h;
		end else begin
			px = cx + h; py = cy + d;
		end
	endtask

	// driver: new transaction at the falling edge once the last one is taken
	always @(negedge clk) begin
		idle_mode_t mode;
		int idle_pct;
		int stall_pct;
		mode = idle_mode_t'((issued / PHASE_ITEMS) % 4);
		case (mode)
			IDLE_NONE: begin idle_pct = 0; stall_pct = 0; end
			IDLE_SENDER: begin idle_pct = 71; stall_pct = 0; end
			IDLE_RECEIVER: begin idle_pct = 0; stall_pct = 71; end
			default: begin idle_pct = 31; stall_pct = 31; end
		endcase
		if (arst_n && !(in_valid && !in_taken)) begin
			if (arc_items.size() != 0 && $urandom_range(99) >= idle_pct) begin
				in_item <= arc_items.pop_front();
				in_valid <= 1'b1;
				issued <= issued + 1;
			end else begin
				in_valid <= 1'b0;
			end
		end
		out_ready <= arst_n && ($urandom_range(99) >= stall_pct);
	end

	// monitor: predict on input transactions, check output transactions
	always @(posedge clk) begin
		caps_pkg::caps_out_t want;
		in_taken <= in_valid && in_ready;
		if (arst_n) begin
			if (in_valid && in_ready)
				trace_arc_item(in_item);
			if (out_valid && out_ready) begin
				if (expected_pixels.size() == 0) begin
					if (mismatches < 10)
						$display("unexpected result: x=%0d y=%0d valid=%0b done=%0b",
							out_item.pixel_x, out_item.pixel_y,
							out_item.point_valid, out_item.arc_done);
					mismatches++;
				end else begin
					want = expected_pixels.pop_front();
					if (out_item.pixel_x !== want.pixel_x || out_item.pixel_y !== want.pixel_y ||
						out_item.point_valid !== want.point_valid ||
						out_item.arc_done !== want.arc_done) begin
						if (mismatches < 10)
							$display("mismatch: expected x=%0d y=%0d valid=%0b done=%0b",
								want.pixel_x, want.pixel_y, want.point_valid, want.arc_done,
								", got x=%0d y=%0d valid=%0b done=%0b",
								out_item.pixel_x, out_item.pixel_y,
								out_item.point_valid, out_item.arc_done);
						mismatches++;
					end
				end
			end
		end
	end

	// stimulus, reset and end of run
	initial begin
		longint cx, cy, px, py, ex, ey, r;
		int kind;
		int steps;

		// step with no arc loaded
		arc_items.push_back(random_item(caps_pkg::OP_STEP));
		// radius exactly at the cutoff, then just above it
		queue_arc(0, 0, 24, 0, 0, -24, MIN_RADIUS, 1);
		queue_arc(0, 0, 25, 0, 0, -25, MIN_RADIUS + 1, 3);
		// extreme fields, start far off the circle, pixel wrap
		queue_arc(524287, 524287, -524288, -524288, -524288, 524287, 262143, 3);
		queue_arc(-524288, -524288, 524287, 524287, 524287, -524288, 262143, 3);
		// start and end at the center
		queue_arc(0, 0, 0, 0, 0, 0, 640, 4);
		// zero radius
		queue_arc(0, 0, 0, 0, 0, 0, 0, 1);

		// random arcs
		while (arc_items.size() < RANDOM_ITEMS) begin
			kind = $urandom_range(99);
			if (kind < 80) begin
				if (kind < 8)
					r = longint'($urandom_range(31, 2000)) * ONE;
				else
					r = longint'($urandom_range(1, 30)) * ONE;
				r = r + longint'($urandom_range(ONE - 1));
				cx = longint'($urandom_range(960000)) - 480000;
				cy = longint'($urandom_range(960000)) - 480000;
				circle_point(r, cx, cy, px, py);
				circle_point(r, cx, cy, ex, ey);
				steps = (kind < 8) ? $urandom_range(3, 12) : $urandom_range(3, 60);
				queue_arc(cx, cy, px, py, ex, ey, r, steps);
			end else begin
				arc_items.push_back(random_item(caps_pkg::OP_LOAD));
				repeat ($urandom_range(1, 6))
					arc_items.push_back(random_item(caps_pkg::OP_STEP));
			end
		end

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (arc_items.size() != 0 || in_valid)
			@(posedge clk);
		while (expected_pixels.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (expected_pixels.size() != 0)
			mismatches++;

		if (mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	// hang guard
	initial begin
		#(5_000_000);
		$display("status: fail");
		$finish;
	end

endmodule

// ===== circle_arc_pixel_stepper_top.f =====
hdl/caps_pkg.sv
hdl/caps_root.sv
hdl/circle_arc_pixel_stepper_top.sv
sim/circle_arc_pixel_stepper_top_test.sv
